FILE: rtl/line_resample_fir_argb_unit_defines.svh
// ----------------------------------------------------------------------------
// line_resample_fir_argb_unit_defines
// Assertion macros used by the checker file of the resampler block.
// ----------------------------------------------------------------------------
`ifndef LINE_RESAMPLE_FIR_ARGB_UNIT_DEFINES_SVH
`define LINE_RESAMPLE_FIR_ARGB_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define LRF_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define LRF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Sizes, field layout and codes of the horizontal line resampler.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int MAX_LINE  = 2048;
    localparam int MAX_OUT   = 1024;
    localparam int MAX_TAPS  = 16;
    localparam int FRAC_BITS = 22;

    localparam int LINE_AW  = $clog2(MAX_LINE);
    localparam int OUT_AW   = $clog2(MAX_OUT);
    localparam int COEFF_AW = $clog2(MAX_OUT * MAX_TAPS);

    localparam int IDX_W   = 14;
    localparam int PIX_W   = 32;
    localparam int COEF_W  = 32;
    localparam int START_W = 11;
    localparam int LEN_W   = 5;
    localparam int TAPS_W  = 5;
    localparam int COUNT_W = 11;
    localparam int WIN_W   = START_W + LEN_W;

    // accumulator: 2^21 + 16 * 255 * 2^31 fits well inside 46 signed bits
    localparam int PROD_W = PIX_W + 9;
    localparam int ACC_W  = 46;

    // input word layout
    localparam int IN_IDX_LO   = 0;
    localparam int IN_PIX_LO   = IN_IDX_LO + IDX_W;
    localparam int IN_COEF_LO  = IN_PIX_LO + PIX_W;
    localparam int IN_START_LO = IN_COEF_LO + COEF_W;
    localparam int IN_LEN_LO   = IN_START_LO + START_W;
    localparam int IN_USED_W   = IN_LEN_LO + LEN_W;
    localparam int S_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // output word layout
    localparam int OUT_POS_LO = 0;
    localparam int OUT_PIX_LO = OUT_POS_LO + OUT_AW;
    localparam int OUT_USED_W = OUT_PIX_LO + PIX_W;
    localparam int M_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    localparam int MODE_W   = 2;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = COUNT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL   = 2'd0,
        MODE_COEFF   = 2'd1,
        MODE_WINDOW  = 2'd2,
        MODE_COMPUTE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TAPS  = 1'b0,
        CFG_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic clear;    // preset the lane accumulators
        logic tap_vld;  // memory read data holds a tap to add
    } mac_ctrl_t;

endpackage

FILE: rtl/lrf_ram.sv
// ----------------------------------------------------------------------------
// lrf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lrf_mac.sv
// ----------------------------------------------------------------------------
// lrf_mac
// Four byte-lane multiply-accumulate with rounding preset and 0..255 clamp.
// ----------------------------------------------------------------------------
module lrf_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrf_pkg::mac_ctrl_t              ctrl,
    input  logic [lrf_pkg::PIX_W-1:0]       pixel,
    input  logic signed [lrf_pkg::COEF_W-1:0] coeff,
    output logic                            busy,
    output logic [lrf_pkg::PIX_W-1:0]       result
);
    import lrf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [ACC_W-1:0]  acc_reg  [4];
    logic                     prod_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.tap_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i] <= $signed({1'b0, pixel[8*i +: 8]}) * coeff;
            if (ctrl.clear)
            begin
                acc_reg[i] <= ACC_W'(1) <<< (FRAC_BITS - 1);
            end
            else if (prod_vld_reg)
            begin
                acc_reg[i] <= acc_reg[i] + ACC_W'(prod_reg[i]);
            end
        end
    end

    // negative -> 0, anything at or above 256 << 22 -> 255
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (acc_reg[i][ACC_W-1])
            begin
                result[8*i +: 8] = 8'd0;
            end
            else if (|acc_reg[i][ACC_W-2:FRAC_BITS+8])
            begin
                result[8*i +: 8] = 8'hFF;
            end
            else
            begin
                result[8*i +: 8] = acc_reg[i][FRAC_BITS +: 8];
            end
        end
    end

    assign busy = prod_vld_reg;

endmodule

FILE: rtl/line_resample_fir_argb_unit.sv
// A compute word with an effective window of L taps passes ST_WIN, ST_TAP for each tap
// and ST_DRAIN (straight from ST_WIN when L = 0); taps past the line end add nothing.
// The input is ready again with the output word: a new compute word waits for the last one.
// Load words produce no output; a held output word stalls the drain.
// rst_n (async, active low) clears control state and sets taps_per_output = 1,
// out_count = 1; line, coefficient and window memories are undefined until written.
// ----------------------------------------------------------------------------
// line_resample_fir_argb_unit
// Horizontal FIR pass of a fixed-point resampler over one line of ARGB pixels.
// ----------------------------------------------------------------------------
module line_resample_fir_argb_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrf_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [lrf_pkg::CFG_DW-1:0]        cfg_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index[13:0], pixel[45:14], coeff[77:46], window_start[88:78],
    // window_len[93:89], zero pad[95:94]
    input  logic [lrf_pkg::S_DATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  logic [lrf_pkg::MODE_W-1:0]        s_tuser,
    // output words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_position[9:0], out_pixel[41:10], zero pad[47:42]
    output logic [lrf_pkg::M_DATA_W-1:0]      m_tdata,
    // last_of_line
    output logic                              m_tlast
);
    import lrf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_TAP,
        ST_DRAIN
    } state_t;

    state_t               state_reg;
    logic [TAPS_W-1:0]    taps_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [OUT_AW-1:0]    idx_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [START_W-1:0]   start_reg;
    logic [COEFF_AW-1:0]  base_reg;
    logic [LEN_W-1:0]     tap_cnt_reg;
    logic                 tap_vld_reg;
    logic                 m_tvalid_reg;
    logic [OUT_AW-1:0]    out_pos_reg;
    logic [PIX_W-1:0]     out_pix_reg;
    logic                 out_last_reg;

    logic                 s_fire;
    mode_t                mode;
    logic [IDX_W-1:0]     in_idx;
    logic [TAPS_W-1:0]    cfg_taps;
    logic [COUNT_W-1:0]   cfg_count;

    logic [LINE_AW:0]     src;
    logic                 issue;
    logic                 out_free;
    logic                 out_load;

    logic                 line_we;
    logic                 coeff_we;
    logic                 win_we;
    logic                 win_re;
    logic [PIX_W-1:0]     line_rdata;
    logic [COEF_W-1:0]    coeff_rdata;
    logic [WIN_W-1:0]     win_rdata;
    logic [LEN_W-1:0]     win_len;
    logic [LEN_W-1:0]     len_eff;
    logic [OUT_AW+TAPS_W-1:0] base_full;

    mac_ctrl_t            mac_ctrl;
    logic                 mac_busy;
    logic [PIX_W-1:0]     mac_result;

    assign mode   = mode_t'(s_tuser);
    assign in_idx = s_tdata[IN_IDX_LO +: IDX_W];
    assign s_fire = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // last product has landed in the accumulators and the output register is free
    assign out_load  = (state_reg == ST_DRAIN) && !tap_vld_reg && !mac_busy && out_free;

    assign line_we  = s_fire && (mode == MODE_PIXEL) && (32'(in_idx) < MAX_LINE);
    assign coeff_we = s_fire && (mode == MODE_COEFF)
                      && (32'(in_idx) < MAX_OUT * MAX_TAPS);
    assign win_we   = s_fire && (mode == MODE_WINDOW) && (32'(in_idx) < MAX_OUT);
    assign win_re   = s_fire && (mode == MODE_COMPUTE) && (in_idx < IDX_W'(count_reg));

    // tap source index; an index past the line end contributes nothing
    assign issue = (state_reg == ST_TAP);
    assign src   = (LINE_AW + 1)'(start_reg) + (LINE_AW + 1)'(tap_cnt_reg);

    assign win_len   = win_rdata[START_W +: LEN_W];
    assign len_eff   = (win_len > taps_reg) ? taps_reg : win_len;
    assign base_full = idx_reg * taps_reg;

    assign cfg_taps  = cfg_data[TAPS_W-1:0];
    assign cfg_count = cfg_data[COUNT_W-1:0];

    lrf_ram #(.DEPTH(MAX_LINE), .WIDTH(PIX_W)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (in_idx[LINE_AW-1:0]),
        .wdata (s_tdata[IN_PIX_LO +: PIX_W]),
        .re    (issue),
        .raddr (src[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    lrf_ram #(.DEPTH(MAX_OUT * MAX_TAPS), .WIDTH(COEF_W)) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (in_idx[COEFF_AW-1:0]),
        .wdata (s_tdata[IN_COEF_LO +: COEF_W]),
        .re    (issue),
        .raddr (base_reg + COEFF_AW'(tap_cnt_reg)),
        .rdata (coeff_rdata)
    );

    lrf_ram #(.DEPTH(MAX_OUT), .WIDTH(WIN_W)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (in_idx[OUT_AW-1:0]),
        .wdata (s_tdata[IN_START_LO +: WIN_W]),
        .re    (win_re),
        .raddr (in_idx[OUT_AW-1:0]),
        .rdata (win_rdata)
    );

    assign mac_ctrl.clear   = (state_reg == ST_WIN);
    assign mac_ctrl.tap_vld = tap_vld_reg;

    lrf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .pixel  (line_rdata),
        .coeff  (coeff_rdata),
        .busy   (mac_busy),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            taps_reg     <= TAPS_W'(1);
            count_reg    <= COUNT_W'(1);
            tap_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            len_reg      <= '0;
            start_reg    <= '0;
            base_reg     <= '0;
            tap_cnt_reg  <= '0;
            out_pos_reg  <= '0;
            out_pix_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_TAPS:
                    begin
                        if (cfg_taps == '0)
                            taps_reg <= TAPS_W'(1);
                        else if (32'(cfg_taps) > MAX_TAPS)
                            taps_reg <= TAPS_W'(MAX_TAPS);
                        else
                            taps_reg <= cfg_taps;
                    end
                    CFG_COUNT:
                    begin
                        if (cfg_count == '0)
                            count_reg <= COUNT_W'(1);
                        else if (32'(cfg_count) > MAX_OUT)
                            count_reg <= COUNT_W'(MAX_OUT);
                        else
                            count_reg <= cfg_count;
                    end
                endcase
            end

            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            tap_vld_reg <= issue && !src[LINE_AW];

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (win_re)
                    begin
                        idx_reg   <= in_idx[OUT_AW-1:0];
                        state_reg <= ST_WIN;
                    end
                end
                ST_WIN:
                begin
                    len_reg     <= len_eff;
                    start_reg   <= win_rdata[START_W-1:0];
                    base_reg    <= base_full[COEFF_AW-1:0];
                    tap_cnt_reg <= '0;
                    state_reg   <= (len_eff == '0) ? ST_DRAIN : ST_TAP;
                end
                ST_TAP:
                begin
                    tap_cnt_reg <= tap_cnt_reg + LEN_W'(1);
                    if (tap_cnt_reg == len_reg - LEN_W'(1))
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    // wait for the last product to land in the accumulators and for a free output register
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_pos_reg  <= idx_reg;
                        out_pix_reg  <= mac_result;
                        out_last_reg <= (COUNT_W'(idx_reg) == count_reg - COUNT_W'(1));
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_pix_reg, out_pos_reg});

endmodule

FILE: rtl/line_resample_fir_argb_unit_checker.sv
// ----------------------------------------------------------------------------
// line_resample_fir_argb_unit_checker
// Port-level assertions for the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_resample_fir_argb_unit_defines.svh"

module line_resample_fir_argb_unit_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lrf_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [lrf_pkg::MODE_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lrf_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);
    import lrf_pkg::*;

    logic s_fire;
    logic load_fire;
    logic far_fire;

    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (s_tuser != MODE_COMPUTE);
    // a position at or beyond the output table is dropped
    assign far_fire  = s_fire && (s_tuser == MODE_COMPUTE)
                       && (s_tdata[IDX_W-1:OUT_AW] != '0);

    `LRF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "output word dropped while stalled")
    `LRF_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
    `LRF_ASSERT_NEXT(a_load_ready, clk, rst_n, load_fire, s_tready,
        "load word did not return to ready")
    `LRF_ASSERT_NEXT(a_far_ready, clk, rst_n, far_fire, s_tready,
        "out-of-range position started a computation")
    `LRF_ASSERT_SAME(a_new_out, clk, rst_n, $rose(m_tvalid), !$past(s_tready),
        "output word appeared without a computation")

endmodule

bind line_resample_fir_argb_unit line_resample_fir_argb_unit_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
